// ----- rtl/givens_rotation_chain_applier_macros.svh -----
// Assertion macros shared by the checker of the rotation chain applier
`ifndef GIVENS_ROTATION_CHAIN_APPLIER_MACROS_SVH
`define GIVENS_ROTATION_CHAIN_APPLIER_MACROS_SVH

// concurrent assertion, masked while reset is held
`define GRCA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("grca assertion failed");

// concurrent assertion that also holds across reset
`define GRCA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("grca assertion failed");

`endif

// ----- rtl/grca_pkg.sv -----
// Package: widths, mode codes, item types and rounding for the rotation chain
`timescale 1ns / 1ps
package grca_pkg;

    localparam int DATA_W = 32;
    localparam int ROW_W  = 5;
    localparam int SLOT_W = 3;
    localparam int MODE_W = 2;
    localparam int CS_W   = 18;
    localparam int PROD_W = DATA_W + CS_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - 16;

    localparam int DEF_ROWS  = 32;
    localparam int DEF_CHAIN = 6;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PRE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROT   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd3;

    localparam logic signed [Q_W-1:0] Q_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 35'sh7_8000_0000;

    // item as it travels down the rotation stages
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [ROW_W-1:0]         row;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] x;
    } t_item;

    // occupancy of one pipeline register, for the row interlock
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
    } t_occ;

    // add one half, shift right by 16, saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] b;
        logic signed [Q_W-1:0]   q;
        b = s + SUM_W'(32768);
        q = b[SUM_W-1:16];
        if (q > Q_MAX) begin
            return Q_MAX[DATA_W-1:0];
        end else if (q < Q_MIN) begin
            return Q_MIN[DATA_W-1:0];
        end
        return q[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/grca_if.sv -----
// Handshake interfaces for input items and result items
`timescale 1ns / 1ps
interface grca_in_if import grca_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [ROW_W-1:0]         row;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] sample_in;
    logic signed [CS_W-1:0]   cos_value;
    logic signed [CS_W-1:0]   sin_value;

    modport source (output valid, mode, row, slot, sample_in, cos_value, sin_value,
                    input ready);
    modport sink   (input valid, mode, row, slot, sample_in, cos_value, sin_value,
                    output ready);
endinterface

interface grca_out_if import grca_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ROW_W-1:0]         out_row;
    logic signed [DATA_W-1:0] sample_out;
    logic                     last;

    modport source (output valid, out_row, sample_out, last, input ready);
    modport sink   (input valid, out_row, sample_out, last, output ready);
endinterface

// ----- rtl/grca_stage.sv -----
// One rotation of the chain: held-value read, four products, round and write back
`timescale 1ns / 1ps
module grca_stage import grca_pkg::*; #(
    parameter int ROWS  = DEF_ROWS,
    parameter int CHAIN = DEF_CHAIN,
    parameter int K     = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  t_item                             i_item,
    input  logic [CHAIN-1:0][DATA_W-1:0]      i_vals,
    input  logic signed [CS_W-1:0]            i_cos,
    input  logic signed [CS_W-1:0]            i_sin,
    output logic                              o_valid,
    output t_item                             o_item,
    output logic [CHAIN-1:0][DATA_W-1:0]      o_vals,
    output t_occ                              o_occ [3]
);

    localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT  = CHAIN - 1 - K;

    // held values of this stage's slot, one per row
    logic [DATA_W-1:0] r_mem [ROWS];

    logic r_v1, r_v2, r_v3;
    t_item r_it1, r_it2, r_it3;
    logic [CHAIN-1:0][DATA_W-1:0] r_vals1, r_vals2, r_vals3;
    logic signed [DATA_W-1:0] r_h1, r_h2;
    logic signed [PROD_W-1:0] r_p_ch, r_p_sx, r_p_cx, r_p_sh;

    logic signed [DATA_W-1:0] w_t, w_hn, w_wdata;
    logic w_wen;
    t_item n_it3;
    logic [CHAIN-1:0][DATA_W-1:0] n_vals3;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // rounded sums and the write back of the slot
    always_comb begin
        w_t  = rnd_sat(SUM_W'(r_p_ch) + SUM_W'(r_p_sx));
        w_hn = rnd_sat(SUM_W'(r_p_cx) - SUM_W'(r_p_sh));
        n_it3 = r_it2;
        n_vals3 = r_vals2;
        if (r_it2.mode == MODE_ROT) begin
            n_it3.x = w_t;
        end
        if (r_it2.mode == MODE_DRAIN) begin
            n_vals3[SLOT] = r_h2;
        end
        w_wen = r_v2 && ((r_it2.mode == MODE_ROT) ||
                ((r_it2.mode == MODE_PRE) && ({1'b0, r_it2.slot} == 4'(SLOT))));
        w_wdata = (r_it2.mode == MODE_ROT) ? w_hn : r_it2.x;
    end

    // payload registers and the slot memory
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_it1   <= i_item;
            r_vals1 <= i_vals;
            r_h1    <= r_mem[IDX_W'(i_item.row)];
            r_it2   <= r_it1;
            r_vals2 <= r_vals1;
            r_h2    <= r_h1;
            r_p_ch  <= i_cos * r_h1;
            r_p_sx  <= i_sin * r_it1.x;
            r_p_cx  <= i_cos * r_it1.x;
            r_p_sh  <= i_sin * r_h1;
            r_it3   <= n_it3;
            r_vals3 <= n_vals3;
            if (w_wen) begin
                r_mem[IDX_W'(r_it2.row)] <= w_wdata;
            end
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_it3;
    assign o_vals  = r_vals3;
    assign o_occ[0] = '{valid: r_v1, row: r_it1.row};
    assign o_occ[1] = '{valid: r_v2, row: r_it2.row};
    assign o_occ[2] = '{valid: r_v3, row: r_it3.row};

endmodule

// ----- rtl/grca_out.sv -----
// Result register: one result for a rotate, CHAIN results for a drain
`timescale 1ns / 1ps
module grca_out import grca_pkg::*; #(
    parameter int CHAIN = DEF_CHAIN
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  t_item                        i_item,
    input  logic [CHAIN-1:0][DATA_W-1:0] i_vals,
    output logic                         o_adv,
    grca_out_if.source                   o_out_ch
);

    localparam int CNT_W = (CHAIN > 1) ? $clog2(CHAIN) : 1;

    logic r_busy, r_drain;
    logic [ROW_W-1:0] r_row;
    logic [DATA_W-1:0] r_x;
    logic [CHAIN-1:0][DATA_W-1:0] r_vals;
    logic [CNT_W-1:0] r_cnt;

    logic w_last, w_fire, w_free, w_res, w_load;

    always_comb begin
        w_last = !r_drain || (r_cnt == CNT_W'(CHAIN - 1));
        w_fire = r_busy && o_out_ch.ready;
        w_free = !r_busy || (w_fire && w_last);
        // preloads carry no result and leave the pipe freely
        w_res  = (i_item.mode == MODE_ROT) || (i_item.mode == MODE_DRAIN);
        o_adv  = w_free || !(i_valid && w_res);
        w_load = i_valid && w_res && w_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_fire) begin
            r_busy <= !w_last;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_drain <= (i_item.mode == MODE_DRAIN);
            r_row   <= i_item.row;
            r_x     <= i_item.x;
            r_vals  <= i_vals;
        end
    end

    assign o_out_ch.valid      = r_busy;
    assign o_out_ch.out_row    = r_row;
    assign o_out_ch.sample_out = r_drain ? r_vals[r_cnt] : r_x;
    assign o_out_ch.last       = w_last;

endmodule

// ----- rtl/givens_rotation_chain_applier.sv -----
// A rotate or drain item passes the 3*CHAIN stage registers, then the result
// register. Throughput: one item per cycle while rows differ and results are
// taken; an item whose row is still inside the stage registers waits for it, and
// a cos/sin load waits for an empty pipe. A drain holds the result register
// until its CHAIN results are taken. Reset clears valid bits and the result
// register; held values and cos/sin pairs are undefined until written.
`timescale 1ns / 1ps
module givens_rotation_chain_applier import grca_pkg::*; #(
    parameter int ROWS  = DEF_ROWS,
    parameter int CHAIN = DEF_CHAIN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    grca_in_if.sink     i_in_ch,
    grca_out_if.source  o_out_ch
);

    logic signed [CS_W-1:0] r_cos [CHAIN];
    logic signed [CS_W-1:0] r_sin [CHAIN];

    logic w_v [CHAIN+1];
    t_item w_it [CHAIN+1];
    logic [CHAIN-1:0][DATA_W-1:0] w_vals [CHAIN+1];
    t_occ w_occ [CHAIN][3];

    logic w_adv, w_hazard, w_busy, w_accept, w_in_range;

    // row interlock and empty check over all stage registers
    always_comb begin
        w_hazard = 1'b0;
        w_busy   = 1'b0;
        for (int k = 0; k < CHAIN; k++) begin
            for (int j = 0; j < 3; j++) begin
                w_busy = w_busy | w_occ[k][j].valid;
                if (w_occ[k][j].valid && (w_occ[k][j].row == i_in_ch.row)) begin
                    w_hazard = 1'b1;
                end
            end
        end
        i_in_ch.ready = w_adv && ((i_in_ch.mode == MODE_LOAD) ? !w_busy : !w_hazard);
        w_accept   = i_in_ch.valid && i_in_ch.ready;
        w_in_range = 32'(i_in_ch.row) < ROWS;
        w_v[0]     = w_accept && (i_in_ch.mode != MODE_LOAD) && w_in_range;
        w_it[0]    = '{mode: i_in_ch.mode, row: i_in_ch.row, slot: i_in_ch.slot,
                       x: i_in_ch.sample_in};
        w_vals[0]  = '0;
    end

    // cos/sin pairs, one per rotation
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < CHAIN; j++) begin
            if (w_accept && (i_in_ch.mode == MODE_LOAD) &&
                ({1'b0, i_in_ch.slot} == 4'(j))) begin
                r_cos[j] <= i_in_ch.cos_value;
                r_sin[j] <= i_in_ch.sin_value;
            end
        end
    end

    // rotation stages
    for (genvar k = 0; k < CHAIN; k++) begin : g_stage
        grca_stage #(.ROWS(ROWS), .CHAIN(CHAIN), .K(k)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_v[k]),
            .i_item  (w_it[k]),
            .i_vals  (w_vals[k]),
            .i_cos   (r_cos[k]),
            .i_sin   (r_sin[k]),
            .o_valid (w_v[k+1]),
            .o_item  (w_it[k+1]),
            .o_vals  (w_vals[k+1]),
            .o_occ   (w_occ[k])
        );
    end

    grca_out #(.CHAIN(CHAIN)) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_v[CHAIN]),
        .i_item   (w_it[CHAIN]),
        .i_vals   (w_vals[CHAIN]),
        .o_adv    (w_adv),
        .o_out_ch (o_out_ch)
    );

endmodule

// ----- rtl/grca_checker.sv -----
// Port checker for the rotation chain applier, bound to the top level
`timescale 1ns / 1ps
`include "givens_rotation_chain_applier_macros.svh"
module grca_checker import grca_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_out_last,
    input logic [ROW_W-1:0]   i_out_row,
    input logic [DATA_W-1:0]  i_sample_out
);

    // no result shows right after reset
    `GRCA_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid)

    // results of one drain follow each other for the same row
    `GRCA_ASSERT(a_drain_cont, i_clk, i_rst_n,
        (i_out_valid && i_out_ready && !i_out_last) |=> (i_out_valid && $stable(i_out_row)))

    // a stalled result holds
    `GRCA_ASSERT(a_out_hold, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_sample_out)))

endmodule

bind givens_rotation_chain_applier grca_checker u_grca_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_out_last   (o_out_ch.last),
    .i_out_row    (o_out_ch.out_row),
    .i_sample_out (o_out_ch.sample_out)
);
